// ===== sv/mecv_pkg.sv =====
// ----------------------------------------------------------------------------
// MIDI event to CV command converter: shared types and constants
// Holds the result item layout, the MIDI and NRPN codes, the NRPN parser
// phases and helpers that build DAC and gate commands.
// ----------------------------------------------------------------------------
package mecv_pkg;

   // One command for the CV hardware.
   typedef struct packed {
      logic        kind;
      logic [2:0]  target;
      logic [15:0] dac_word;
      logic        pin_level;
      logic        last;
   } result_type;

   // Event actions.
   localparam logic [1:0] ACT_NOTE_OFF = 2'd0;
   localparam logic [1:0] ACT_NOTE_ON  = 2'd1;
   localparam logic [1:0] ACT_CTRL     = 2'd2;

   // Command kinds.
   localparam logic KIND_DAC  = 1'b0;
   localparam logic KIND_GATE = 1'b1;

   // Channels and limits.
   localparam logic [3:0] CV_CHANNEL   = 4'd0;
   localparam logic [3:0] NRPN_CHANNEL = 4'd15;
   localparam logic [3:0] NOTE_CHANNELS = 4'd8;
   localparam logic [3:0] GATE_CHANNELS = 4'd2;
   localparam logic [6:0] NOTE_MAX     = 7'd120;
   localparam logic [6:0] CC_DAC_END   = 7'd8;
   localparam logic [6:0] CC_GATE_END  = 7'd10;

   // NRPN controller numbers.
   localparam logic [6:0] CC_NRPN_MSB  = 7'd99;
   localparam logic [6:0] CC_NRPN_LSB  = 7'd98;
   localparam logic [6:0] CC_DATA_MSB  = 7'd6;
   localparam logic [6:0] CC_DATA_LSB  = 7'd38;
   localparam logic [13:0] NRPN_ADDR_MAX = 14'd7;

   // NRPN parser phases.
   localparam logic [2:0] PH_IDLE     = 3'd0;
   localparam logic [2:0] PH_ADDR_MSB = 3'd1;
   localparam logic [2:0] PH_ADDR     = 3'd2;
   localparam logic [2:0] PH_VAL_MSB  = 3'd3;
   localparam logic [2:0] PH_VAL_LSB  = 3'd4;

   // DAC control nibble.
   localparam logic [3:0] DAC_CTRL = 4'h6;

   // Build a DAC write command.
   function automatic result_type dac_result(input logic [2:0] tgt, input logic [11:0] data);
      result_type r;
      r.kind      = KIND_DAC;
      r.target    = tgt;
      r.dac_word  = {DAC_CTRL, data};
      r.pin_level = 1'b0;
      r.last      = 1'b0;
      return r;
   endfunction

   // Build a gate pin write command.
   function automatic result_type gate_result(input logic [2:0] pin, input logic lvl);
      result_type r;
      r.kind      = KIND_GATE;
      r.target    = pin;
      r.dac_word  = 16'd0;
      r.pin_level = lvl;
      r.last      = 1'b0;
      return r;
   endfunction

endpackage

// ===== sv/mecv_decode.sv =====
// ----------------------------------------------------------------------------
// MIDI event decoder
// Turns one registered event into zero, one or two commands and keeps the
// NRPN parser state, which advances when the event is handed on.
// ----------------------------------------------------------------------------
module mecv_decode
   import mecv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  logic [1:0] action,
   input  logic [3:0] channel,
   input  logic [6:0] number,
   input  logic [6:0] level,
   output result_type res0,
   output result_type res1,
   output logic [1:0] count
);

   logic [2:0]  phase_ff, phase_in;
   logic [13:0] addr_ff, addr_in;
   logic [13:0] value_ff, value_in;
   logic [10:0] note_x17;
   logic [11:0] note_data;
   logic [11:0] cc_data;
   logic        emit;
   result_type  r0, r1;
   logic [1:0]  n;

   // note * 102 / 12 equals (note * 17) >> 1.
   assign note_x17  = {number, 4'b0000} + {4'b0000, number};
   assign note_data = {2'b00, note_x17[10:1]};

   // Controller value scaled by eight, odd values fill the low bits.
   assign cc_data = {2'b00, level, {3{level[0]}}};

   // Command selection and NRPN parsing.
   always_comb begin
      phase_in = phase_ff;
      addr_in  = addr_ff;
      value_in = value_ff;
      emit     = 1'b0;
      r0       = '0;
      r1       = '0;
      n        = 2'd0;
      if (action == ACT_NOTE_OFF || action == ACT_NOTE_ON) begin
         if (channel < NOTE_CHANNELS && number <= NOTE_MAX) begin
            if (channel < GATE_CHANNELS) begin
               r0 = gate_result(channel[2:0], action[0]);
               r1 = dac_result(channel[2:0], note_data);
               n  = 2'd2;
            end else begin
               r0 = dac_result(channel[2:0], note_data);
               n  = 2'd1;
            end
         end
      end else if (action == ACT_CTRL) begin
         if (channel == CV_CHANNEL) begin
            if (number < CC_DAC_END) begin
               r0 = dac_result(number[2:0], cc_data);
               n  = 2'd1;
            end else if (number < CC_GATE_END) begin
               r0 = gate_result({2'b00, number[0]}, |level);
               n  = 2'd1;
            end
         end else if (channel == NRPN_CHANNEL) begin
            case (number)
               CC_NRPN_MSB: begin
                  addr_in  = {level, 7'd0};
                  phase_in = PH_ADDR_MSB;
               end
               CC_NRPN_LSB: begin
                  if (phase_ff == PH_ADDR_MSB) begin
                     addr_in  = addr_ff | {7'd0, level};
                     phase_in = PH_ADDR;
                  end
               end
               CC_DATA_MSB: begin
                  if (phase_ff == PH_ADDR) begin
                     phase_in = PH_VAL_MSB;
                     value_in = {level, 7'd0};
                     emit     = 1'b1;
                  end
               end
               CC_DATA_LSB: begin
                  if (phase_ff == PH_VAL_MSB) begin
                     phase_in = PH_VAL_LSB;
                     value_in = value_ff | {7'd0, level};
                     emit     = 1'b1;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
            if (emit && addr_in <= NRPN_ADDR_MAX) begin
               r0 = dac_result(addr_in[2:0], {2'b00, value_in[13:4]});
               n  = 2'd1;
            end
         end
      end
      // Mark the final command of this event.
      if (n == 2'd1) begin
         r0.last = 1'b1;
      end
      if (n == 2'd2) begin
         r1.last = 1'b1;
      end
   end

   assign res0  = r0;
   assign res1  = r1;
   assign count = n;

   // NRPN state advances only when the event is consumed.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         addr_ff  <= '0;
         value_ff <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         addr_ff  <= addr_in;
         value_ff <= value_in;
      end
   end

endmodule

// ===== sv/mecv_out_buf.sv =====
// ----------------------------------------------------------------------------
// Command output buffer
// Two-entry result register: takes all commands of one event at once and
// presents them one per cycle on the result channel while it accepts them.
// ----------------------------------------------------------------------------
module mecv_out_buf
   import mecv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type res0,
   input  result_type res1,
   input  logic [1:0] count,
   input  logic       pop,
   output logic       can_load,
   output logic       head_valid,
   output result_type head,
   output logic [1:0] fill
);

   result_type head_ff, tail_ff;
   logic [1:0] cnt_ff;

   // A new event fits when the buffer is empty or drains in this cycle.
   assign can_load   = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && pop);
   assign head_valid = (cnt_ff != 2'd0);
   assign head       = head_ff;
   assign fill       = cnt_ff;

   // Payload entries.
   always_ff @(posedge clock) begin
      if (load) begin
         head_ff <= res0;
         tail_ff <= res1;
      end else if (pop) begin
         head_ff <= tail_ff;
      end
   end

   // Entry count.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else if (load) begin
         cnt_ff <= count;
      end else if (pop) begin
         cnt_ff <= cnt_ff - 2'd1;
      end
   end

endmodule

// ===== sv/midi_event_to_cv_commands.sv =====
// ----------------------------------------------------------------------------
// MIDI event to CV command converter
// Converts decoded MIDI events into gate pin writes and DAC SPI words.
// ----------------------------------------------------------------------------
// Each event is registered, decoded combinationally into up to two commands
// and placed in a two-entry output buffer. Events giving zero or one command
// stream at one per clock while the result side accepts them; a note on
// channel 0 or 1 gives a gate write followed by a DAC word and occupies the
// result port for both, which then sets the sustained rate. Events reach the
// result port through the input register and the output buffer. NRPN state
// on channel 15 is updated in event order as events leave the input register.
module midi_event_to_cv_commands
   import mecv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // action
   input  logic [23:0] req_tdata,   // channel[3:0], number[10:4], level[17:11]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic        rsp_tuser,   // kind
   output logic [23:0] rsp_tdata,   // target[2:0], dac_word[18:3], pin_level[19]
   output logic        rsp_tlast
);

   logic       in_valid_ff;
   logic [1:0] action_ff;
   logic [3:0] channel_ff;
   logic [6:0] number_ff;
   logic [6:0] level_ff;
   logic       fire;
   logic       pop;
   logic       can_load;
   logic [1:0] count;
   logic [1:0] fill;
   result_type res0, res1, head;

   assign fire       = in_valid_ff && can_load;
   assign req_tready = !in_valid_ff || fire;
   assign pop        = rsp_tvalid && rsp_tready;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         action_ff  <= req_tuser;
         channel_ff <= req_tdata[3:0];
         number_ff  <= req_tdata[10:4];
         level_ff   <= req_tdata[17:11];
      end
   end

   // Event decode and NRPN parser.
   mecv_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .action  (action_ff),
      .channel (channel_ff),
      .number  (number_ff),
      .level   (level_ff),
      .res0    (res0),
      .res1    (res1),
      .count   (count)
   );

   // Result buffer.
   mecv_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .load       (fire),
      .res0       (res0),
      .res1       (res1),
      .count      (count),
      .pop        (pop),
      .can_load   (can_load),
      .head_valid (rsp_tvalid),
      .head       (head),
      .fill       (fill)
   );

   // Result channel packing.
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;
   assign rsp_tdata = {4'b0000, head.pin_level, head.dac_word, head.target};

   // A gate write never carries a DAC word.
   a_gate_no_word: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_GATE |-> rsp_tdata[18:3] == 16'd0)
      else $error("gate command carries a DAC word");

   // A DAC write carries the control nibble and no gate level.
   a_dac_ctrl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_DAC |-> rsp_tdata[18:15] == DAC_CTRL && !rsp_tdata[19])
      else $error("DAC command malformed");

   // With two commands buffered, the one in front is not the final one.
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      fill == 2'd2 |-> !rsp_tlast)
      else $error("first of a command pair marked last");

   // The buffer never takes an event while full.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      fire |-> fill != 2'd2)
      else $error("event loaded into a full buffer");

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// Testbench for the MIDI event to CV command converter
// A short table of directed MIDI events is sent first, then random notes,
// control changes and NRPN sequences. Both stream ports idle at random, and once
// the result side holds off for a long time. Each command is checked field by
// field against the row's typed expectation or a predictor with its own NRPN state.
// ----------------------------------------------------------------------------
module tb;
   import mecv_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Note pitch scaling: DAC code = note * 102 / 12.
   localparam int NOTE_SCALE_MUL = 102;
   localparam int NOTE_SCALE_DIV = 12;
   localparam int RANDOM_EVENTS  = 1300;
   localparam int LONG_HOLD      = 400;
   localparam int DRAIN_LIMIT    = 5000;
   localparam result_type NO_CMD = '0;
   // Action code with no meaning; the block ignores it.
   localparam logic [1:0] ACT_RESERVED = 2'd3;

   // One MIDI event to send; n_typed >= 0 means the expected commands are
   // given in the row instead of coming from the predictor.
   typedef struct {
      logic [1:0] action;
      logic [3:0] chan;
      logic [6:0] num;
      logic [6:0] lvl;
      int         n_typed;
      result_type r0;
      result_type r1;
   } midi_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser = '0;    // action
   logic [23:0] req_tdata = '0;    // channel[3:0], number[10:4], level[17:11]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic        rsp_tuser;         // kind
   logic [23:0] rsp_tdata;         // target[2:0], dac_word[18:3], pin_level[19]
   logic        rsp_tlast;

   // Predictor copy of the NRPN parser.
   logic [2:0]  nrpn_stage;
   logic [13:0] param_addr;
   logic [13:0] param_data;

   result_type  pending_cmds[$];
   int          mismatches = 0;
   int          events_sent = 0;
   int          active_events = 0;
   int          cmds_seen = 0;
   int          gate_writes = 0;
   int          dac_writes = 0;
   bit          req_burst = 1'b0;
   bit          long_hold_done = 1'b0;

   midi_event_to_cv_commands dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #10 clock = ~clock;

   function automatic result_type dac_cmd(input logic [2:0] tgt, input logic [11:0] data);
      result_type c;
      c = '0;
      c.kind     = KIND_DAC;
      c.target   = tgt;
      c.dac_word = {DAC_CTRL, data};
      return c;
   endfunction

   function automatic result_type gate_cmd(input logic [2:0] pin, input logic lvl);
      result_type c;
      c = '0;
      c.kind      = KIND_GATE;
      c.target    = pin;
      c.pin_level = lvl;
      return c;
   endfunction

   // Work out the commands one event causes and advance the NRPN parser.
   function automatic int convert_event(input logic [1:0] action, input logic [3:0] chan,
                                        input logic [6:0] num, input logic [6:0] lvl,
                                        output result_type cmds[2]);
      int n;
      bit emit;
      n = 0;
      emit = 1'b0;
      cmds[0] = NO_CMD;
      cmds[1] = NO_CMD;
      if (action == ACT_NOTE_OFF || action == ACT_NOTE_ON) begin
         if (chan < NOTE_CHANNELS && num <= NOTE_MAX) begin
            if (chan < GATE_CHANNELS) begin
               cmds[n] = gate_cmd(chan[2:0], action == ACT_NOTE_ON);
               n++;
            end
            cmds[n] = dac_cmd(chan[2:0], 12'((int'(num) * NOTE_SCALE_MUL) / NOTE_SCALE_DIV));
            n++;
         end
      end else if (action == ACT_CTRL) begin
         if (chan == CV_CHANNEL) begin
            // Controllers below 8 set a DAC; odd values fill the low three bits.
            if (num < CC_DAC_END) begin
               cmds[n] = dac_cmd(num[2:0], {2'b00, lvl, {3{lvl[0]}}});
               n++;
            end else if (num < CC_GATE_END) begin
               cmds[n] = gate_cmd(3'(num - CC_DAC_END), lvl != 7'd0);
               n++;
            end
         end else if (chan == NRPN_CHANNEL) begin
            case (num)
               CC_NRPN_MSB: begin
                  param_addr = {lvl, 7'd0};
                  nrpn_stage = PH_ADDR_MSB;
               end
               CC_NRPN_LSB: begin
                  if (nrpn_stage == PH_ADDR_MSB) begin
                     param_addr = param_addr | 14'(lvl);
                     nrpn_stage = PH_ADDR;
                  end
               end
               CC_DATA_MSB: begin
                  if (nrpn_stage == PH_ADDR) begin
                     nrpn_stage = PH_VAL_MSB;
                     param_data = {lvl, 7'd0};
                     emit = 1'b1;
                  end
               end
               CC_DATA_LSB: begin
                  if (nrpn_stage == PH_VAL_MSB) begin
                     nrpn_stage = PH_VAL_LSB;
                     param_data = param_data | 14'(lvl);
                     emit = 1'b1;
                  end
               end
               default: nrpn_stage = PH_IDLE;
            endcase
            if (emit && param_addr <= NRPN_ADDR_MAX) begin
               cmds[n] = dac_cmd(param_addr[2:0], {2'b00, param_data[13:4]});
               n++;
            end
         end
      end
      if (n > 0)
         cmds[n - 1].last = 1'b1;
      return n;
   endfunction

   function automatic midi_item_type make_row(input logic [1:0] action, input logic [3:0] chan,
                                              input logic [6:0] num, input logic [6:0] lvl,
                                              input int n_typed, input result_type r0,
                                              input result_type r1);
      midi_item_type it;
      it.action  = action;
      it.chan    = chan;
      it.num     = num;
      it.lvl     = lvl;
      it.n_typed = n_typed;
      it.r0      = r0;
      it.r1      = r1;
      return it;
   endfunction

   // Offer one event after a random gap and record what it should cause.
   task automatic send_event(input midi_item_type it);
      result_type cmds[2];
      int n;
      int gap;
      if ($urandom_range(0, 39) == 0)
         req_burst = !req_burst;
      gap = req_burst ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= it.action;
      req_tdata  <= {6'd0, it.lvl, it.num, it.chan};
      do @(posedge clock); while (!req_tready);
      n = convert_event(it.action, it.chan, it.num, it.lvl, cmds);
      if (it.n_typed >= 0) begin
         n = it.n_typed;
         cmds[0] = it.r0;
         cmds[1] = it.r1;
      end
      for (int i = 0; i < n; i++)
         pending_cmds.push_back(cmds[i]);
      if (n > 0 || (it.action == ACT_CTRL && it.chan == NRPN_CHANNEL))
         active_events++;
      events_sent++;
   endtask

   function automatic void check_field(input string what, input logic [15:0] want,
                                       input logic [15:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
         mismatches++;
      end
   endfunction

   // Compare every accepted command with the oldest expectation.
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         cmds_seen++;
         if (rsp_tuser == KIND_GATE)
            gate_writes++;
         else
            dac_writes++;
         if (pending_cmds.size() == 0) begin
            $display("%0t ns: unexpected command, expected none, actual kind %0d tdata 0x%0h",
                     $time, rsp_tuser, rsp_tdata);
            mismatches++;
         end else begin
            want = pending_cmds.pop_front();
            check_field("kind", 16'(want.kind), 16'(rsp_tuser));
            check_field("target", 16'(want.target), 16'(rsp_tdata[2:0]));
            check_field("dac_word", want.dac_word, rsp_tdata[18:3]);
            check_field("pin_level", 16'(want.pin_level), 16'(rsp_tdata[19]));
            check_field("last", 16'(want.last), 16'(rsp_tlast));
         end
      end
   end

   // Result side: random stalls, bursts without stalls and one long hold-off.
   initial begin : rsp_side
      int stall;
      bit burst;
      burst = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0)
            burst = !burst;
         stall = burst ? 0 : $urandom_range(0, 14);
         if (!long_hold_done && cmds_seen >= 120) begin
            long_hold_done = 1'b1;
            stall = LONG_HOLD;
         end
         if (stall > 0) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Watchdog.
   initial begin
      #20_000_000;
      $display("Some tests failed");
      $finish;
   end

   initial begin : stimulus
      midi_item_type plan[$];
      logic [6:0] seq_ctl[4];
      logic [6:0] seq_lvl[4];
      logic [1:0] act;
      logic [3:0] ch;
      logic [6:0] num;
      int pick;
      int drain;

      nrpn_stage = PH_IDLE;
      param_addr = '0;
      param_data = '0;

      // Directed events: field extremes, every action and the corner cases.
      plan.push_back(make_row(ACT_NOTE_ON, 4'd0, 7'd0, 7'd127, 2,
                              '{KIND_GATE, 3'd0, 16'h0000, 1'b1, 1'b0},
                              '{KIND_DAC, 3'd0, 16'h6000, 1'b0, 1'b1}));
      plan.push_back(make_row(ACT_NOTE_OFF, 4'd1, 7'd120, 7'd0, 2,
                              '{KIND_GATE, 3'd1, 16'h0000, 1'b0, 1'b0},
                              '{KIND_DAC, 3'd1, 16'h63FC, 1'b0, 1'b1}));
      plan.push_back(make_row(ACT_NOTE_ON, 4'd7, 7'd120, 7'd1, 1,
                              '{KIND_DAC, 3'd7, 16'h63FC, 1'b0, 1'b1}, NO_CMD));
      plan.push_back(make_row(ACT_NOTE_ON, 4'd2, 7'd121, 7'd64, 0, NO_CMD, NO_CMD));
      plan.push_back(make_row(ACT_NOTE_ON, 4'd8, 7'd60, 7'd64, 0, NO_CMD, NO_CMD));
      plan.push_back(make_row(ACT_NOTE_OFF, 4'd3, 7'd60, 7'd64, -1, NO_CMD, NO_CMD));
      // The unused action code does nothing, even with a valid-looking payload.
      plan.push_back(make_row(ACT_RESERVED, 4'd0, 7'd0, 7'd127, 0, NO_CMD, NO_CMD));
      plan.push_back(make_row(ACT_CTRL, 4'd0, 7'd0, 7'd0, 1,
                              '{KIND_DAC, 3'd0, 16'h6000, 1'b0, 1'b1}, NO_CMD));
      plan.push_back(make_row(ACT_CTRL, 4'd0, 7'd7, 7'd127, 1,
                              '{KIND_DAC, 3'd7, 16'h63FF, 1'b0, 1'b1}, NO_CMD));
      plan.push_back(make_row(ACT_CTRL, 4'd0, 7'd3, 7'd64, -1, NO_CMD, NO_CMD));
      plan.push_back(make_row(ACT_CTRL, 4'd0, 7'd8, 7'd0, 1,
                              '{KIND_GATE, 3'd0, 16'h0000, 1'b0, 1'b1}, NO_CMD));
      plan.push_back(make_row(ACT_CTRL, 4'd0, 7'd9, 7'd1, 1,
                              '{KIND_GATE, 3'd1, 16'h0000, 1'b1, 1'b1}, NO_CMD));
      plan.push_back(make_row(ACT_CTRL, 4'd0, 7'd10, 7'd127, 0, NO_CMD, NO_CMD));
      plan.push_back(make_row(ACT_CTRL, 4'd0, 7'd127, 7'd127, 0, NO_CMD, NO_CMD));
      plan.push_back(make_row(ACT_CTRL, 4'd5, 7'd0, 7'd5, 0, NO_CMD, NO_CMD));
      // NRPN: an address LSB out of order, then a full sequence to DAC 5.
      plan.push_back(make_row(ACT_CTRL, NRPN_CHANNEL, CC_NRPN_LSB, 7'd3, -1, NO_CMD, NO_CMD));
      plan.push_back(make_row(ACT_CTRL, NRPN_CHANNEL, CC_NRPN_MSB, 7'd0, -1, NO_CMD, NO_CMD));
      plan.push_back(make_row(ACT_CTRL, NRPN_CHANNEL, CC_NRPN_LSB, 7'd5, -1, NO_CMD, NO_CMD));
      plan.push_back(make_row(ACT_CTRL, NRPN_CHANNEL, CC_DATA_MSB, 7'd127, -1, NO_CMD, NO_CMD));
      plan.push_back(make_row(ACT_CTRL, NRPN_CHANNEL, CC_DATA_LSB, 7'd127, -1, NO_CMD, NO_CMD));
      // A data MSB after the value is complete is out of order.
      plan.push_back(make_row(ACT_CTRL, NRPN_CHANNEL, CC_DATA_MSB, 7'd3, -1, NO_CMD, NO_CMD));
      // An address above 7 updates the parser but writes nothing.
      plan.push_back(make_row(ACT_CTRL, NRPN_CHANNEL, CC_NRPN_MSB, 7'd1, -1, NO_CMD, NO_CMD));
      plan.push_back(make_row(ACT_CTRL, NRPN_CHANNEL, CC_NRPN_LSB, 7'd127, -1, NO_CMD, NO_CMD));
      plan.push_back(make_row(ACT_CTRL, NRPN_CHANNEL, CC_DATA_MSB, 7'd10, -1, NO_CMD, NO_CMD));
      // Any other controller on the NRPN channel sends the parser back to idle.
      plan.push_back(make_row(ACT_CTRL, NRPN_CHANNEL, 7'd20, 7'd0, -1, NO_CMD, NO_CMD));

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i])
         send_event(plan[i]);

      // Random part, weighted toward well-formed NRPN sequences and valid notes.
      seq_ctl = '{CC_NRPN_MSB, CC_NRPN_LSB, CC_DATA_MSB, CC_DATA_LSB};
      while (events_sent < plan.size() + RANDOM_EVENTS) begin
         pick = $urandom_range(0, 9);
         if (pick <= 2) begin
            act = 2'($urandom_range(0, 1));
            ch  = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                              : 4'($urandom_range(0, 7));
            num = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                              : 7'($urandom_range(0, 120));
            send_event(make_row(act, ch, num, 7'($urandom_range(0, 127)), -1, NO_CMD, NO_CMD));
         end else if (pick <= 4) begin
            num = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
                                              : 7'($urandom_range(0, 9));
            send_event(make_row(ACT_CTRL, CV_CHANNEL, num, 7'($urandom_range(0, 127)), -1,
                                NO_CMD, NO_CMD));
         end else if (pick <= 7) begin
            seq_lvl[0] = ($urandom_range(0, 5) == 0) ? 7'($urandom_range(0, 127)) : 7'd0;
            seq_lvl[1] = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                     : 7'($urandom_range(0, 7));
            seq_lvl[2] = 7'($urandom_range(0, 127));
            seq_lvl[3] = 7'($urandom_range(0, 127));
            for (int s = 0; s < 4; s++) begin
               // Now and then a stray controller or a dropped step breaks the sequence.
               if ($urandom_range(0, 11) == 0)
                  send_event(make_row(ACT_CTRL, NRPN_CHANNEL, 7'($urandom_range(0, 127)),
                                      7'($urandom_range(0, 127)), -1, NO_CMD, NO_CMD));
               if ($urandom_range(0, 11) != 0)
                  send_event(make_row(ACT_CTRL, NRPN_CHANNEL, seq_ctl[s], seq_lvl[s], -1,
                                      NO_CMD, NO_CMD));
            end
         end else if (pick == 8) begin
            send_event(make_row(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                                7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)), -1,
                                NO_CMD, NO_CMD));
         end else begin
            act = ($urandom_range(0, 1) == 0) ? ACT_CTRL : ACT_RESERVED;
            send_event(make_row(act, 4'($urandom_range(1, 14)), 7'($urandom_range(0, 127)),
                                7'($urandom_range(0, 127)), -1, NO_CMD, NO_CMD));
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;

      // Let the outstanding commands drain, then allow for the pipeline latency.
      drain = 0;
      while (pending_cmds.size() > 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (10) @(posedge clock);
      if (pending_cmds.size() > 0) begin
         $display("%0t ns: %0d expected commands never arrived", $time, pending_cmds.size());
         mismatches += pending_cmds.size();
      end

      $display("Sent %0d MIDI events (%0d notes, CVs or NRPN messages), checked %0d commands",
               events_sent, active_events, cmds_seen);
      $display("  %0d gate writes, %0d DAC writes, long result stall %s, %0d mismatches",
               gate_writes, dac_writes, long_hold_done ? "done" : "not reached", mismatches);
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
